FILE: src/cprc_pkg.sv
// ---------------------------------------------------------------------------
// cprc_pkg
// shared types, constants and the byte-wide crc-16 update for the
// counter page response checker
// ---------------------------------------------------------------------------
package cprc_pkg;

   localparam int POS_W       = 6;
   localparam int CNT_BYTES   = 4;
   localparam int REQ_TDATA_W = 24;
   localparam int RSP_TDATA_W = 48;

   localparam logic [7:0]  CMD_READ_COUNTER = 8'hA5;
   localparam logic [15:0] CRC_POLY         = 16'hA001;
   localparam logic [15:0] CRC_GOOD         = 16'hFFFF;

   typedef enum logic {
      CMD_START = 1'b0,
      CMD_BYTE  = 1'b1
   } cmd_type;

   typedef struct packed {
      cmd_type     cmd;
      logic [15:0] page_address;
      logic [7:0]  rx_byte;
   } req_item_type;

   typedef struct packed {
      logic [31:0] counter_value;
      logic        crc_ok;
      logic [15:0] frame_page;
   } result_type;

   // reflected crc-16, one byte, lsb first
   function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {8'h00, b};
      for (int k = 0; k < 8; k++) begin
         if (c[0]) begin
            c = (c >> 1) ^ CRC_POLY;
         end else begin
            c = c >> 1;
         end
      end
      return c;
   endfunction

   // crc after the command byte alone, from an all-zero start
   localparam logic [15:0] CRC_SEED = crc_byte(16'h0000, CMD_READ_COUNTER);

endpackage

FILE: src/cprc_in_reg.sv
// ---------------------------------------------------------------------------
// cprc_in_reg
// input register: holds one request transfer until the frame stage takes it
// ---------------------------------------------------------------------------
module cprc_in_reg
   import cprc_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic                   req_tuser,
   input  logic [REQ_TDATA_W-1:0] req_tdata,
   input  logic                   advance,
   output logic                   item_valid,
   output req_item_type           item
);

   logic         valid_ff, valid_in;
   req_item_type item_ff, item_in;
   logic         take;

   assign req_tready = !reset && (!valid_ff || advance);
   assign take       = req_tvalid && req_tready;

   always_comb begin
      valid_in = valid_ff;
      item_in  = item_ff;
      if (take) begin
         valid_in          = 1'b1;
         item_in.cmd       = cmd_type'(req_tuser);
         item_in.page_address = req_tdata[15:0];
         item_in.rx_byte   = req_tdata[23:16];
      end else if (advance) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff <= item_in;
   end

   assign item_valid = valid_ff;
   assign item       = item_ff;

endmodule

FILE: src/cprc_frame.sv
// ---------------------------------------------------------------------------
// cprc_frame
// frame tracking: crc update, byte position, counter assembly, final check
// ---------------------------------------------------------------------------
module cprc_frame
   import cprc_pkg::*;
#(
   parameter int PAGE_BYTES   = 32,
   parameter int FILLER_BYTES = 4
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         item_valid,
   input  req_item_type item,
   input  logic         out_space,
   output logic         advance,
   output logic         res_valid,
   output result_type   res
);

   localparam logic [POS_W-1:0] CNT_FIRST  = POS_W'(PAGE_BYTES);
   localparam logic [POS_W-1:0] CNT_END    = POS_W'(PAGE_BYTES + CNT_BYTES);
   localparam logic [POS_W-1:0] CRC_LO_POS = POS_W'(PAGE_BYTES + CNT_BYTES + FILLER_BYTES);

   logic [15:0]      crc_ff, crc_in;
   logic [POS_W-1:0] pos_ff, pos_in;
   logic [31:0]      acc_ff, acc_in;
   logic [15:0]      page_ff, page_in;
   logic             active_ff, active_in;

   logic [POS_W-1:0] cnt_idx;
   logic [15:0]      fin;

   assign advance = item_valid && out_space;
   assign cnt_idx = pos_ff - CNT_FIRST;
   assign fin     = crc_ff ^ {item.rx_byte, 8'h00};

   always_comb begin
      crc_in    = crc_ff;
      pos_in    = pos_ff;
      acc_in    = acc_ff;
      page_in   = page_ff;
      active_in = active_ff;
      res_valid = 1'b0;
      res.counter_value = (fin == CRC_GOOD) ? acc_ff : 32'h0;
      res.crc_ok        = (fin == CRC_GOOD);
      res.frame_page    = page_ff;
      if (advance) begin
         if (item.cmd == CMD_START) begin
            crc_in    = crc_byte(crc_byte(CRC_SEED, item.page_address[7:0]),
                                 item.page_address[15:8]);
            pos_in    = '0;
            acc_in    = '0;
            page_in   = item.page_address;
            active_in = 1'b1;
         end else if (active_ff) begin
            if (pos_ff < CRC_LO_POS) begin
               crc_in = crc_byte(crc_ff, item.rx_byte);
               if (pos_ff >= CNT_FIRST && pos_ff < CNT_END) begin
                  acc_in = acc_ff | ({24'h0, item.rx_byte} << {cnt_idx[1:0], 3'b000});
               end
               pos_in = pos_ff + 1'b1;
            end else if (pos_ff == CRC_LO_POS) begin
               crc_in = crc_ff ^ {8'h00, item.rx_byte};
               pos_in = pos_ff + 1'b1;
            end else begin
               // high crc byte closes the frame
               crc_in    = fin;
               pos_in    = '0;
               active_in = 1'b0;
               res_valid = 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         crc_ff    <= '0;
         pos_ff    <= '0;
         acc_ff    <= '0;
         page_ff   <= '0;
         active_ff <= 1'b0;
      end else begin
         crc_ff    <= crc_in;
         pos_ff    <= pos_in;
         acc_ff    <= acc_in;
         page_ff   <= page_in;
         active_ff <= active_in;
      end
   end

endmodule

FILE: src/cprc_out_reg.sv
// ---------------------------------------------------------------------------
// cprc_out_reg
// result register in front of the response channel
// ---------------------------------------------------------------------------
module cprc_out_reg
   import cprc_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   load,
   input  result_type             res,
   output logic                   out_space,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic                   rsp_tuser,
   output logic [RSP_TDATA_W-1:0] rsp_tdata
);

   logic       valid_ff, valid_in;
   result_type res_ff, res_in;

   assign out_space = !valid_ff || rsp_tready;

   always_comb begin
      valid_in = valid_ff;
      res_in   = res_ff;
      if (load) begin
         valid_in = 1'b1;
         res_in   = res;
      end else if (rsp_tready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      res_ff <= res_in;
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tuser  = res_ff.crc_ok;
   assign rsp_tdata  = {res_ff.frame_page, res_ff.counter_value};

endmodule

FILE: src/counter_page_response_checker.sv
// rsp_tvalid is registered: the high crc byte passes the input register, then the result register
// throughput: one request transfer per cycle while the response side keeps up
// the figure is set by the combinational byte crc update between input and result registers
// a full result register with rsp_tready low stalls the request side
// reset: synchronous, active high; drops any open frame and empties both registers
// ---------------------------------------------------------------------------
// counter_page_response_checker
// checks the reply to a read-memory-with-counter command: crc-16 over
// command, address and reply bytes, and the little-endian page counter
// ---------------------------------------------------------------------------
module counter_page_response_checker
   import cprc_pkg::*;
#(
   parameter int PAGE_BYTES   = 32,
   parameter int FILLER_BYTES = 4
) (
   input  logic                   clock,
   input  logic                   reset,
   // request channel
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic                   req_tuser,  // cmd: 0 start of frame, 1 received byte
   input  logic [REQ_TDATA_W-1:0] req_tdata,  // page_address[15:0], rx_byte[23:16]
   // response channel
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic                   rsp_tuser,  // crc_ok
   output logic [RSP_TDATA_W-1:0] rsp_tdata   // counter_value[31:0], frame_page[47:32]
);

   logic         advance;
   logic         item_valid;
   req_item_type item;
   logic         out_space;
   logic         res_valid;
   result_type   res;

   // input register: one request transfer held for the frame stage
   cprc_in_reg u_in_reg (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .advance    (advance),
      .item_valid (item_valid),
      .item       (item)
   );

   // frame state and crc check; moves one item per cycle when the
   // result register has room
   cprc_frame #(
      .PAGE_BYTES   (PAGE_BYTES),
      .FILLER_BYTES (FILLER_BYTES)
   ) u_frame (
      .clock      (clock),
      .reset      (reset),
      .item_valid (item_valid),
      .item       (item),
      .out_space  (out_space),
      .advance    (advance),
      .res_valid  (res_valid),
      .res        (res)
   );

   // result register; loads only on the closing byte of a frame
   cprc_out_reg u_out_reg (
      .clock      (clock),
      .reset      (reset),
      .load       (res_valid),
      .res        (res),
      .out_space  (out_space),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tuser  (rsp_tuser),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

FILE: src/cprc_checker.sv
// ---------------------------------------------------------------------------
// cprc_checker
// port-level checks for the counter page response checker
// ---------------------------------------------------------------------------
module cprc_checker
   import cprc_pkg::*;
(
   input logic                   clock,
   input logic                   reset,
   input logic                   req_tready,
   input logic                   rsp_tvalid,
   input logic                   rsp_tready,
   input logic                   rsp_tuser,
   input logic [RSP_TDATA_W-1:0] rsp_tdata
);

   // no request transfer while in reset
   a_reset_no_accept: assert property (@(posedge clock) reset |-> !req_tready)
      else $error("request accepted during reset");

   // no result right after reset
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result valid after reset");

   // a failed crc never carries a counter
   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tuser) |-> (rsp_tdata[31:0] == 32'h0))
      else $error("nonzero counter on crc failure");

   // stalled result stays
   a_hold_valid: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> rsp_tvalid)
      else $error("result dropped while stalled");

   // stalled result payload is stable
   a_hold_data: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> ($stable(rsp_tdata) && $stable(rsp_tuser)))
      else $error("result changed while stalled");

endmodule

bind counter_page_response_checker cprc_checker u_cprc_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tuser  (rsp_tuser),
   .rsp_tdata  (rsp_tdata)
);
